// ===== rtl/mgbpm_pkg.sv =====
// Shared types, constants and codes of the mixed-grain block page map.
`default_nettype none
package mgbpm_pkg;

  localparam int LOGICAL_BLOCKS  = 64;
  localparam int PHYS_BLOCKS     = 64;
  localparam int PAGES_PER_BLOCK = 512;

  localparam int FUNC_W   = 2;
  localparam int LBF_W    = 6;   // logical_block field
  localparam int PIF_W    = 9;   // page_index field
  localparam int PNF_W    = 15;  // phys_number field
  localparam int STATUS_W = 2;
  localparam int OFF_W    = 48;
  localparam int DSO_W    = 40;

  localparam int LB_W    = $clog2(LOGICAL_BLOCKS);
  localparam int PI_W    = $clog2(PAGES_PER_BLOCK);
  localparam int PB_W    = $clog2(PHYS_BLOCKS);
  localparam int PG_W    = PB_W + PI_W;
  localparam int PGA_W   = LB_W + PI_W;
  localparam int PG_DEPTH = LOGICAL_BLOCKS * PAGES_PER_BLOCK;

  localparam int BLOCK_SHIFT = 21;
  localparam int PAGE_SHIFT  = 12;
  localparam logic [OFF_W-1:0] OFFSET_MASK = 48'hffff_ffff_f000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MAP_BLOCK = 2'd0,
    FUNC_MAP_PAGE  = 2'd1,
    FUNC_SPLIT     = 2'd2,
    FUNC_QUERY     = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_UNMAPPED = 2'd0,
    MODE_COARSE   = 2'd1,
    MODE_FINE     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PG_SRC_SINGLE = 2'd0,
    PG_SRC_CLEAR  = 2'd1,
    PG_SRC_SPLIT  = 2'd2
  } pg_src_t;

  typedef enum logic [1:0] {
    OFF_NONE  = 2'd0,
    OFF_BLOCK = 2'd1,
    OFF_PAGE  = 2'd2
  } off_sel_t;

  typedef struct packed {
    mode_t            mode;
    logic [PB_W-1:0]  target;
  } blk_entry_t;

  typedef struct packed {
    logic             valid;
    logic [PG_W-1:0]  target;
  } pg_entry_t;

  typedef struct packed {
    logic     in_ready;
    logic     load;
    logic     blk_wr;
    mode_t    blk_mode;
    logic     pg_wr;
    pg_src_t  pg_src;
    logic     out_load;
    status_t  res_status;
    off_sel_t res_sel;
    logic     res_fine;
  } ctrl_cmd_t;

  typedef struct packed {
    logic   in_valid;
    func_t  func;
    logic   rng_err;
    mode_t  mode;
    logic   pg_valid;
    logic   walk_last;
    logic   out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/mgbpm_if.sv =====
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface mgbpm_in_if;
  logic                        valid;
  logic                        ready;
  logic [mgbpm_pkg::FUNC_W-1:0] func;
  logic [mgbpm_pkg::LBF_W-1:0]  logical_block;
  logic [mgbpm_pkg::PIF_W-1:0]  page_index;
  logic [mgbpm_pkg::PNF_W-1:0]  phys_number;

  modport source (output valid, func, logical_block, page_index, phys_number,
                  input ready);
  modport sink (input valid, func, logical_block, page_index, phys_number,
                output ready);
endinterface

interface mgbpm_out_if;
  logic                           valid;
  logic                           ready;
  logic [mgbpm_pkg::STATUS_W-1:0] status;
  logic [mgbpm_pkg::OFF_W-1:0]    phys_offset;
  logic                           fine_grain;

  modport source (output valid, status, phys_offset, fine_grain, input ready);
  modport sink (input valid, status, phys_offset, fine_grain, output ready);
endinterface
`default_nettype wire

// ===== rtl/mgbpm_dp.sv =====
// Datapath: item registers, block and page tables, walk counter, output register.
`default_nettype none
module mgbpm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mgbpm_pkg::DSO_W-1:0]  cfg_wr_data,
  mgbpm_in_if.sink                          in_ch,
  mgbpm_out_if.source                       out_ch,
  input  wire mgbpm_pkg::ctrl_cmd_t         cmd,
  output mgbpm_pkg::ctrl_stat_t             stat
);

  logic [mgbpm_pkg::DSO_W-1:0] dso;
  mgbpm_pkg::func_t            func_q;
  logic [mgbpm_pkg::LBF_W-1:0] lb_q;
  logic [mgbpm_pkg::PIF_W-1:0] pi_q;
  logic [mgbpm_pkg::PNF_W-1:0] pn_q;
  logic [mgbpm_pkg::PI_W-1:0]  cnt;

  mgbpm_pkg::blk_entry_t blk_mem [mgbpm_pkg::LOGICAL_BLOCKS];
  logic [mgbpm_pkg::LOGICAL_BLOCKS-1:0] blk_vld;
  mgbpm_pkg::blk_entry_t blk_rd;
  logic                  blk_vld_rd;

  mgbpm_pkg::pg_entry_t pg_mem [mgbpm_pkg::PG_DEPTH];
  mgbpm_pkg::pg_entry_t pg_rd;
  mgbpm_pkg::pg_entry_t pg_wdata;
  logic [mgbpm_pkg::PGA_W-1:0] pg_waddr;

  logic [mgbpm_pkg::LB_W-1:0] lb_idx;
  logic [mgbpm_pkg::PI_W-1:0] pi_idx;
  logic lb_bad, pi_bad, pn_blk_bad, pn_pg_bad;
  logic [mgbpm_pkg::OFF_W-1:0] term;
  logic [mgbpm_pkg::OFF_W-1:0] offset;

  logic                           out_valid;
  logic [mgbpm_pkg::STATUS_W-1:0] out_status;
  logic [mgbpm_pkg::OFF_W-1:0]    out_offset;
  logic                           out_fine;

  assign lb_idx = lb_q[mgbpm_pkg::LB_W-1:0];
  assign pi_idx = pi_q[mgbpm_pkg::PI_W-1:0];

  // Config register and item capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      dso <= '0;
    end else if (cfg_wr_en) begin
      dso <= cfg_wr_data;
    end
    if (cmd.load) begin
      func_q <= mgbpm_pkg::func_t'(in_ch.func);
      lb_q   <= in_ch.logical_block;
      pi_q   <= in_ch.page_index;
      pn_q   <= in_ch.phys_number;
    end
  end

  // Walk counter over the pages of one block.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.pg_wr && cmd.pg_src != mgbpm_pkg::PG_SRC_SINGLE) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Block table: read on accept, written at the held block.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_rd     <= blk_mem[in_ch.logical_block[mgbpm_pkg::LB_W-1:0]];
      blk_vld_rd <= blk_vld[in_ch.logical_block[mgbpm_pkg::LB_W-1:0]];
    end
    if (cmd.blk_wr) begin
      blk_mem[lb_idx] <= '{mode: cmd.blk_mode, target: pn_q[mgbpm_pkg::PB_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_vld <= '0;
    end else if (cmd.blk_wr) begin
      blk_vld[lb_idx] <= 1'b1;
    end
  end

  // Page table: one write port, one registered read at the held page.
  always_comb begin
    pg_waddr = {lb_idx, cnt};
    pg_wdata = '{valid: 1'b0, target: pn_q[mgbpm_pkg::PG_W-1:0]};
    case (cmd.pg_src)
      mgbpm_pkg::PG_SRC_SINGLE: begin
        pg_waddr = {lb_idx, pi_idx};
        pg_wdata = '{valid: 1'b1, target: pn_q[mgbpm_pkg::PG_W-1:0]};
      end
      mgbpm_pkg::PG_SRC_SPLIT: begin
        pg_wdata = '{valid: 1'b1, target: {pn_q[mgbpm_pkg::PB_W-1:0], cnt}};
      end
      default: begin
        pg_wdata = '{valid: 1'b0, target: pn_q[mgbpm_pkg::PG_W-1:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pg_wr) begin
      pg_mem[pg_waddr] <= pg_wdata;
    end
    pg_rd <= pg_mem[{lb_idx, pi_idx}];
  end

  // Range checks on the held item.
  assign lb_bad     = 32'(lb_q) >= 32'(mgbpm_pkg::LOGICAL_BLOCKS);
  assign pi_bad     = 32'(pi_q) >= 32'(mgbpm_pkg::PAGES_PER_BLOCK);
  assign pn_blk_bad = 32'(pn_q) >= 32'(mgbpm_pkg::PHYS_BLOCKS);
  assign pn_pg_bad  = 32'(pn_q) >= 32'(mgbpm_pkg::PHYS_BLOCKS * mgbpm_pkg::PAGES_PER_BLOCK);

  always_comb begin
    stat.in_valid  = in_ch.valid;
    stat.func      = func_q;
    stat.mode      = blk_vld_rd ? blk_rd.mode : mgbpm_pkg::MODE_UNMAPPED;
    stat.pg_valid  = pg_rd.valid;
    stat.walk_last = (cnt == '1);
    stat.out_free  = !out_valid || out_ch.ready;
    case (func_q)
      mgbpm_pkg::FUNC_MAP_PAGE: stat.rng_err = lb_bad || pi_bad || pn_pg_bad;
      mgbpm_pkg::FUNC_QUERY:    stat.rng_err = lb_bad || pi_bad;
      default:                  stat.rng_err = lb_bad || pi_bad || pn_blk_bad;
    endcase
  end

  // Translation: data start plus the shifted block or page number.
  always_comb begin
    case (cmd.res_sel)
      mgbpm_pkg::OFF_BLOCK: term = mgbpm_pkg::OFF_W'(blk_rd.target) << mgbpm_pkg::BLOCK_SHIFT;
      mgbpm_pkg::OFF_PAGE:  term = mgbpm_pkg::OFF_W'(pg_rd.target) << mgbpm_pkg::PAGE_SHIFT;
      default:              term = '0;
    endcase
    offset = (cmd.res_sel == mgbpm_pkg::OFF_NONE) ? '0
           : ((mgbpm_pkg::OFF_W'(dso) + term) & mgbpm_pkg::OFFSET_MASK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_status <= cmd.res_status;
      out_offset <= offset;
      out_fine   <= cmd.res_fine;
    end
  end

  assign in_ch.ready        = cmd.in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.phys_offset = out_offset;
  assign out_ch.fine_grain  = out_fine;

endmodule
`default_nettype wire

// ===== rtl/mgbpm_ctrl.sv =====
// Controller: sequences table reads, page walks, writes and result hand-off.
`default_nettype none
module mgbpm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mgbpm_pkg::ctrl_stat_t stat,
  output mgbpm_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLK,
    S_PG,
    S_WALK,
    S_PMAP,
    S_DONE
  } state_t;

  state_t               state;
  mgbpm_pkg::status_t   res_status;
  mgbpm_pkg::off_sel_t  res_sel;
  logic                 res_fine;

  always_comb begin
    cmd            = '0;
    cmd.blk_mode   = mgbpm_pkg::MODE_FINE;
    cmd.pg_src     = mgbpm_pkg::PG_SRC_SINGLE;
    cmd.res_status = res_status;
    cmd.res_sel    = res_sel;
    cmd.res_fine   = res_fine;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = stat.in_valid;
      end
      S_BLK: begin
        if (!stat.rng_err) begin
          if (stat.func == mgbpm_pkg::FUNC_MAP_BLOCK) begin
            cmd.blk_wr   = 1'b1;
            cmd.blk_mode = mgbpm_pkg::MODE_COARSE;
          end else if (stat.func == mgbpm_pkg::FUNC_MAP_PAGE &&
                       stat.mode == mgbpm_pkg::MODE_FINE) begin
            cmd.pg_wr = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd.pg_wr  = 1'b1;
        cmd.pg_src = (stat.func == mgbpm_pkg::FUNC_SPLIT) ? mgbpm_pkg::PG_SRC_SPLIT
                                                          : mgbpm_pkg::PG_SRC_CLEAR;
        cmd.blk_wr = stat.walk_last && stat.func == mgbpm_pkg::FUNC_SPLIT;
      end
      S_PMAP: begin
        cmd.pg_wr  = 1'b1;
        cmd.blk_wr = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= mgbpm_pkg::ST_OK;
      res_sel    <= mgbpm_pkg::OFF_NONE;
      res_fine   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (stat.in_valid) begin
            state      <= S_BLK;
            res_status <= mgbpm_pkg::ST_OK;
            res_sel    <= mgbpm_pkg::OFF_NONE;
            res_fine   <= 1'b0;
          end
        end
        S_BLK: begin
          state <= S_DONE;
          if (stat.rng_err) begin
            res_status <= mgbpm_pkg::ST_RANGE;
          end else begin
            case (stat.func)
              mgbpm_pkg::FUNC_MAP_PAGE: begin
                if (stat.mode == mgbpm_pkg::MODE_COARSE) begin
                  res_status <= mgbpm_pkg::ST_CONFLICT;
                end else if (stat.mode != mgbpm_pkg::MODE_FINE) begin
                  state <= S_WALK;
                end
              end
              mgbpm_pkg::FUNC_SPLIT: begin
                state <= S_WALK;
              end
              mgbpm_pkg::FUNC_QUERY: begin
                if (stat.mode == mgbpm_pkg::MODE_COARSE) begin
                  res_sel <= mgbpm_pkg::OFF_BLOCK;
                end else if (stat.mode == mgbpm_pkg::MODE_FINE) begin
                  res_fine <= 1'b1;
                  state    <= S_PG;
                end else begin
                  res_status <= mgbpm_pkg::ST_UNMAPPED;
                end
              end
              default: begin
                res_status <= mgbpm_pkg::ST_OK;
              end
            endcase
          end
        end
        S_PG: begin
          state <= S_DONE;
          if (stat.pg_valid) begin
            res_sel <= mgbpm_pkg::OFF_PAGE;
          end else begin
            res_status <= mgbpm_pkg::ST_UNMAPPED;
          end
        end
        S_WALK: begin
          if (stat.walk_last) begin
            state <= (stat.func == mgbpm_pkg::FUNC_SPLIT) ? S_DONE : S_PMAP;
          end
        end
        S_PMAP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mixed_grain_block_page_map.sv =====
// Each word: a block-table read, then for a query of a fine block a page-table read; a
// split and a page map onto an unmapped block sweep all 512 pages of the block, one
// page-table write per cycle, set by the single write port of the page table.
// Throughput: one word at a time; the next word is taken once the result is in the output
// register, while that result still waits to be taken.
// Reset (synchronous): all blocks unmapped, data start offset 0, no clearing pass.
`default_nettype none
module mixed_grain_block_page_map (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mgbpm_pkg::DSO_W-1:0]  cfg_wr_data,
  mgbpm_in_if.sink                          in_ch,
  mgbpm_out_if.source                       out_ch
);

  // The page table needs no reset: a block only turns fine through a split or
  // a first page map, and both sweep all 512 entries of the block first.
  // Block modes carry per-entry valid flops, so an unwritten block reads unmapped.

  mgbpm_pkg::ctrl_cmd_t  cmd;
  mgbpm_pkg::ctrl_stat_t stat;

  // Sequence each word: block read, optional page read or page sweep, write, hand off.
  mgbpm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Hold tables, item registers, translation adder and the output register.
  mgbpm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the mixed-grain block page map.
module tb;
  import mgbpm_pkg::*;

  // Expected content of one result word.
  typedef struct {
    status_t             status;
    logic [OFF_W-1:0]    offset;
    logic                fine;
  } map_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [DSO_W-1:0] cfg_wr_data;

  mgbpm_in_if  in_ch ();
  mgbpm_out_if out_ch ();

  mixed_grain_block_page_map dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Shadow copy of the map tables and the data start register.
  logic [DSO_W-1:0] data_start;
  mode_t            shadow_mode [LOGICAL_BLOCKS];
  logic [PNF_W-1:0] shadow_blk_tgt [LOGICAL_BLOCKS];
  bit               shadow_pg_valid [PG_DEPTH];
  logic [PNF_W-1:0] shadow_pg_tgt [PG_DEPTH];

  // Results of accepted request words, oldest first.
  map_result_t pending_results[$];
  int          mismatch_count;

  // Idle control: no_idle for both sender and receiver, the rest for the receiver.
  bit   no_idle;
  bit   long_hold;
  int   rx_hold_left;
  event hold_start;

  // Free-running clock, period 8.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (2000000) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while no_idle is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offset of a physical block or page: data start plus number scaled,
  // low 12 bits cleared, kept to 48 bits.
  function automatic logic [OFF_W-1:0] translated(logic [PNF_W-1:0] number, int shift);
    logic [OFF_W-1:0] wide;
    wide = OFF_W'(number);
    return (OFF_W'(data_start) + (wide << shift)) & OFFSET_MASK;
  endfunction

  // Apply one request word to the shadow tables and return its result.
  function automatic map_result_t predict_translation(func_t f, logic [LBF_W-1:0] lb,
                                                     logic [PIF_W-1:0] pi,
                                                     logic [PNF_W-1:0] pn);
    map_result_t r;
    int base;
    r.status = ST_OK;
    r.offset = '0;
    r.fine   = 1'b0;
    base     = int'(lb) * PAGES_PER_BLOCK;
    if (int'(lb) >= LOGICAL_BLOCKS || int'(pi) >= PAGES_PER_BLOCK) begin
      r.status = ST_RANGE;
      return r;
    end
    case (f)
      FUNC_MAP_BLOCK: begin
        if (int'(pn) >= PHYS_BLOCKS) begin
          r.status = ST_RANGE;
        end else begin
          shadow_mode[lb]    = MODE_COARSE;
          shadow_blk_tgt[lb] = pn;
        end
      end
      FUNC_MAP_PAGE: begin
        if (int'(pn) >= PHYS_BLOCKS * PAGES_PER_BLOCK) begin
          r.status = ST_RANGE;
        end else if (shadow_mode[lb] == MODE_COARSE) begin
          r.status = ST_CONFLICT;
        end else begin
          // First page of an unmapped block: start from an empty page table.
          if (shadow_mode[lb] != MODE_FINE) begin
            for (int i = 0; i < PAGES_PER_BLOCK; i++) shadow_pg_valid[base + i] = 1'b0;
            shadow_mode[lb] = MODE_FINE;
          end
          shadow_pg_valid[base + int'(pi)] = 1'b1;
          shadow_pg_tgt[base + int'(pi)]   = pn;
        end
      end
      FUNC_SPLIT: begin
        if (int'(pn) >= PHYS_BLOCKS) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = 0; i < PAGES_PER_BLOCK; i++) begin
            shadow_pg_valid[base + i] = 1'b1;
            shadow_pg_tgt[base + i]   = PNF_W'(int'(pn) * PAGES_PER_BLOCK + i);
          end
          shadow_mode[lb] = MODE_FINE;
        end
      end
      default: begin
        if (shadow_mode[lb] == MODE_COARSE) begin
          r.offset = translated(shadow_blk_tgt[lb], BLOCK_SHIFT);
        end else if (shadow_mode[lb] == MODE_FINE) begin
          r.fine = 1'b1;
          if (shadow_pg_valid[base + int'(pi)])
            r.offset = translated(shadow_pg_tgt[base + int'(pi)], PAGE_SHIFT);
          else
            r.status = ST_UNMAPPED;
        end else begin
          r.status = ST_UNMAPPED;
        end
      end
    endcase
    return r;
  endfunction

  // Offer one request word after a random gap, hold it until taken, then
  // record what it must produce.
  task automatic send_word(input func_t f, input logic [LBF_W-1:0] lb,
                           input logic [PIF_W-1:0] pi, input logic [PNF_W-1:0] pn);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.logical_block <= lb;
    in_ch.page_index    <= pi;
    in_ch.phys_number   <= pn;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_translation(f, lb, pi, pn));
  endtask

  // Drop valid and wait until every pending result has been taken, then
  // let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the data start register while the block is idle.
  task automatic set_data_start(input logic [DSO_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    data_start  = value;
  endtask

  // Page index biased toward the edges of a block so that maps and queries meet.
  function automatic logic [PIF_W-1:0] pick_page();
    int v;
    v = $urandom_range(0, 7);
    if ($urandom_range(0, 1) == 0) return PIF_W'($urandom_range(0, PAGES_PER_BLOCK - 1));
    return (v < 4) ? PIF_W'(v) : PIF_W'(PAGES_PER_BLOCK - 8 + v);
  endfunction

  // One random word, and after a map or split, with even odds, a query of the same address.
  task automatic send_random_word();
    int r;
    func_t f;
    logic [LBF_W-1:0] lb;
    logic [PIF_W-1:0] pi;
    logic [PNF_W-1:0] pn;
    r  = $urandom_range(0, 99);
    f  = (r < 45) ? FUNC_QUERY : (r < 72) ? FUNC_MAP_PAGE :
         (r < 88) ? FUNC_MAP_BLOCK : FUNC_SPLIT;
    lb = ($urandom_range(0, 3) == 0) ? LBF_W'($urandom_range(0, 63)) :
                                       LBF_W'($urandom_range(0, 7));
    pi = pick_page();
    if (f == FUNC_MAP_BLOCK || f == FUNC_SPLIT)
      pn = ($urandom_range(0, 9) == 0) ? PNF_W'($urandom_range(0, 32767)) :
                                         PNF_W'($urandom_range(0, PHYS_BLOCKS - 1));
    else
      pn = PNF_W'($urandom_range(0, 32767));
    send_word(f, lb, pi, pn);
    if (f != FUNC_QUERY && $urandom_range(0, 1) == 1)
      send_word(FUNC_QUERY, lb, pi, PNF_W'($urandom_range(0, 32767)));
  endtask

  // Every operation and the corner cases, with fixed values.
  task automatic test_directed_ops();
    send_word(FUNC_QUERY,     6'd0,  9'd0,   15'd0);      // query unmapped block
    send_word(FUNC_MAP_BLOCK, 6'd0,  9'd0,   15'd0);
    send_word(FUNC_QUERY,     6'd0,  9'd0,   15'h7fff);
    send_word(FUNC_MAP_BLOCK, 6'd63, 9'd511, 15'd63);
    send_word(FUNC_QUERY,     6'd63, 9'd511, 15'd0);      // page index ignored when coarse
    send_word(FUNC_MAP_BLOCK, 6'd1,  9'd0,   15'd64);     // physical block out of range
    send_word(FUNC_MAP_BLOCK, 6'd1,  9'd0,   15'h7fff);
    send_word(FUNC_SPLIT,     6'd2,  9'd0,   15'h7fff);
    send_word(FUNC_QUERY,     6'd1,  9'd0,   15'd0);      // still unmapped after range error
    send_word(FUNC_MAP_PAGE,  6'd0,  9'd5,   15'd9);      // page map onto coarse block
    send_word(FUNC_QUERY,     6'd0,  9'd5,   15'd0);
    send_word(FUNC_MAP_PAGE,  6'd5,  9'd0,   15'd0);      // unmapped block turns fine
    send_word(FUNC_QUERY,     6'd5,  9'd0,   15'd0);
    send_word(FUNC_QUERY,     6'd5,  9'd1,   15'd0);      // fine block, page unmapped
    send_word(FUNC_MAP_PAGE,  6'd5,  9'd511, 15'h7fff);
    send_word(FUNC_QUERY,     6'd5,  9'd511, 15'd0);
    send_word(FUNC_SPLIT,     6'd7,  9'd0,   15'd63);
    send_word(FUNC_QUERY,     6'd7,  9'd0,   15'd0);
    send_word(FUNC_QUERY,     6'd7,  9'd511, 15'd0);
    send_word(FUNC_MAP_BLOCK, 6'd5,  9'd0,   15'd1);      // coarse map replaces fine
    send_word(FUNC_QUERY,     6'd5,  9'd511, 15'd0);
    send_word(FUNC_SPLIT,     6'd0,  9'd0,   15'd2);      // split replaces coarse
    send_word(FUNC_QUERY,     6'd0,  9'd3,   15'd0);
    send_word(FUNC_MAP_PAGE,  6'd7,  9'd10,  15'd123);    // remap one page of a split block
    send_word(FUNC_QUERY,     6'd7,  9'd10,  15'd0);
  endtask

  // Query known mappings under the extreme data start settings.
  task automatic test_data_start_extremes();
    logic [DSO_W-1:0] settings [3];
    settings[0] = {DSO_W{1'b1}};
    settings[1] = 40'h0_0000_0fff;   // only bits that get cleared
    settings[2] = '0;
    foreach (settings[k]) begin
      set_data_start(settings[k]);
      send_word(FUNC_QUERY, 6'd63, 9'd0,   15'd0);
      send_word(FUNC_QUERY, 6'd5,  9'd0,   15'd0);
      send_word(FUNC_QUERY, 6'd7,  9'd511, 15'd0);
      send_word(FUNC_QUERY, 6'd0,  9'd511, 15'd0);
    end
  endtask

  // Random traffic under one data start setting.
  task automatic test_random_mix(input logic [DSO_W-1:0] dso, input int count);
    set_data_start(dso);
    no_idle = 1'b0;
    repeat (count) send_random_word();
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    wait_idle();
    no_idle = 1'b1;
    -> hold_start;
    repeat (40) send_random_word();
    no_idle = 1'b0;
  endtask

  // No idle cycles on either side.
  task automatic test_back_to_back();
    wait_idle();
    no_idle = 1'b1;
    repeat (60) send_random_word();
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Main sequence: reset once, then each test in turn.
  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = '0;
    in_ch.logical_block = '0;
    in_ch.page_index    = '0;
    in_ch.phys_number   = '0;
    data_start          = '0;
    mismatch_count      = 0;
    no_idle             = 1'b0;
    for (int i = 0; i < LOGICAL_BLOCKS; i++) shadow_mode[i] = MODE_UNMAPPED;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_data_start_extremes();
    test_random_mix('0, 60);
    test_random_mix({DSO_W{1'b1}}, 60);
    test_backpressure();
    test_random_mix(DSO_W'({$urandom, $urandom}), 60);
    test_back_to_back();
    test_random_mix(40'h0_0000_0fff, 60);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Long hold-off: once triggered, hold ready low, then release it. Count on
  // the rising edge so the receiver sees a settled flag at the falling edge.
  initial begin
    long_hold = 1'b0;
    forever begin
      @(hold_start);
      @(posedge clk);
      long_hold = 1'b1;
      repeat (300) @(posedge clk);
      long_hold = 1'b0;
    end
  end

  // Receiver: drive ready at the falling edge with random stalls.
  initial begin
    out_ch.ready = 1'b0;
    rx_hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
        rx_hold_left = pick_gap();
      end
    end
  end

  // Check each result word against the oldest pending expectation.
  always @(posedge clk) begin
    map_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %0d offset %h fine %b",
                   out_ch.status, out_ch.phys_offset, out_ch.fine_grain);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.phys_offset !== want.offset ||
            out_ch.fine_grain !== want.fine) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d offset %h fine %b, got %0d %h %b",
                     want.status, want.offset, want.fine,
                     out_ch.status, out_ch.phys_offset, out_ch.fine_grain);
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/mgbpm_pkg.sv
rtl/mgbpm_if.sv
rtl/mgbpm_dp.sv
rtl/mgbpm_ctrl.sv
rtl/mixed_grain_block_page_map.sv
tb/tb.sv
